// ----- rtl/bucketized_cuckoo_hash_table_defines.svh -----
// ----------------------------------------------------------------------------
// bucketized cuckoo hash table assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BUCKETIZED_CUCKOO_HASH_TABLE_DEFINES_SVH
`define BUCKETIZED_CUCKOO_HASH_TABLE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BCHT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define BCHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bcht_pkg.sv -----
// ----------------------------------------------------------------------------
// bcht_pkg
// types, codes and constants of the bucketized cuckoo hash table
// ----------------------------------------------------------------------------
`default_nettype none

package bcht_pkg;

    localparam logic [63:0] KEY_EMPTY         = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [15:0] LFSR_MASK         = 16'hB400;
    localparam logic [15:0] LFSR_RESET        = 16'h0001;
    localparam logic [8:0]  KICK_BUDGET_RESET = 9'd256;

    // configuration register indexes
    localparam logic CFG_KICK_BUDGET = 1'b0;
    localparam logic CFG_KICK_SEED   = 1'b1;

    // operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_REJECTED  = 2'd2,
        ST_FAILED    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_EVAL,
        S_KICK,
        S_SWAP
    } state_t;

    // one slot: key in the low half
    typedef struct packed {
        logic [63:0] value;
        logic [63:0] key;
    } slot_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] sh;
        sh = s >> 1;
        return s[0] ? (sh ^ LFSR_MASK) : sh;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bucketized_cuckoo_hash_table.sv -----
// Lookup and insert without eviction: the input transfer is followed by a read of bucket a, a
// read of bucket b and a compare, whose result is registered once the output is free.
// Each eviction adds two bucket reads, a compare, the LFSR remainder and a swap write,
// up to kick_budget evictions; one item at a time, the single read port sets the pace.
// After reset every bucket of the store is cleared before the first item is taken.
// BUCKET_CNT must be a power of two.
// ----------------------------------------------------------------------------
// bucketized_cuckoo_hash_table
// two-choice cuckoo table of 64-bit keys and values with WAYS slots per bucket
// ----------------------------------------------------------------------------
`default_nettype none

module bucketized_cuckoo_hash_table
    import bcht_pkg::*;
#(
    parameter int BUCKET_CNT = 64,
    parameter int WAYS       = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [127:0]  s_tdata,   // key, value
    input  wire logic          s_tuser,   // operation
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [191:0]       m_tdata,   // found_value, leftover_key, leftover_value
    output logic [1:0]         m_tuser,   // status
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [15:0]   cfg_data
);

    localparam int BW        = $clog2(BUCKET_CNT);
    localparam int WW        = $clog2(WAYS);
    localparam int KickRange = 2 * WAYS;
    localparam int RW        = $clog2(KickRange);
    localparam logic [31:0] KickRecip =
        32'(((64'd1 << 32) + 64'(KickRange) - 64'd1) / 64'(KickRange));

    state_t state_reg, state_next;

    logic [8:0]    kick_budget_reg;
    logic [15:0]   lfsr_reg;
    logic [BW-1:0] clear_cnt_reg;
    logic [8:0]    kicks_reg;
    logic          out_valid_reg;

    logic          op_reg;
    logic [63:0]   ck_reg;
    logic [63:0]   cv_reg;
    logic [15:0]   q_reg;
    slot_t [WAYS-1:0] row_a_reg;

    status_t       out_status_reg;
    logic [63:0]   out_found_reg;
    logic [63:0]   out_lk_reg;
    logic [63:0]   out_lv_reg;

    slot_t [WAYS-1:0] row_b;
    slot_t [WAYS-1:0] wr_row;
    slot_t [WAYS-1:0] home_row;
    slot_t [WAYS-1:0] swap_row;
    logic          rd_en;
    logic [BW-1:0] rd_addr;
    logic          wr_en;
    logic [BW-1:0] wr_addr;

    logic [BW-1:0] hash_a;
    logic [BW-1:0] hash_b;

    // bucket choice: low bits of key*37+13 and key*31+11
    assign hash_a = ck_reg[BW-1:0] * BW'(37) + BW'(13);
    assign hash_b = ck_reg[BW-1:0] * BW'(31) + BW'(11);

    bcht_row_mem #(
        .BUCKET_CNT (BUCKET_CNT),
        .WAYS       (WAYS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (row_b),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row)
    );

    // compare both buckets against the carried key
    logic [63:0]   found;
    logic          ua_hit, ub_hit, fa_hit, fb_hit;
    logic [WW-1:0] ua_way, ub_way, fa_way, fb_way;

    always_comb
    begin
        found  = KEY_EMPTY;
        ua_hit = 1'b0;
        ub_hit = 1'b0;
        fa_hit = 1'b0;
        fb_hit = 1'b0;
        ua_way = '0;
        ub_way = '0;
        fa_way = '0;
        fb_way = '0;
        // highest way of the second bucket wins for lookup
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_a_reg[w].key == ck_reg)
            begin
                found = row_a_reg[w].value;
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_b[w].key == ck_reg)
            begin
                found = row_b[w].value;
            end
        end
        // lowest way first for insert
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row_a_reg[w].key == ck_reg)
            begin
                ua_hit = 1'b1;
                ua_way = WW'(w);
            end
            if (row_b[w].key == ck_reg)
            begin
                ub_hit = 1'b1;
                ub_way = WW'(w);
            end
            if (row_a_reg[w].key == KEY_EMPTY)
            begin
                fa_hit = 1'b1;
                fa_way = WW'(w);
            end
            if (row_b[w].key == KEY_EMPTY)
            begin
                fb_hit = 1'b1;
                fb_way = WW'(w);
            end
        end
    end

    // home slot and the row written for it
    logic          home_hit;
    logic          home_b;
    logic          home_fill;
    logic [WW-1:0] home_way;

    always_comb
    begin
        home_hit  = ua_hit || ub_hit || fa_hit || fb_hit;
        home_b    = !ua_hit && (ub_hit || (!fa_hit && fb_hit));
        home_fill = !ua_hit && !ub_hit;
        if (ua_hit)
        begin
            home_way = ua_way;
        end
        else if (ub_hit)
        begin
            home_way = ub_way;
        end
        else if (fa_hit)
        begin
            home_way = fa_way;
        end
        else
        begin
            home_way = fb_way;
        end
        home_row = home_b ? row_b : row_a_reg;
        home_row[home_way].value = cv_reg;
        if (home_fill)
        begin
            home_row[home_way].key = ck_reg;
        end
    end

    // eviction choice: lfsr mod 2*WAYS by reciprocal and one correction
    logic [47:0]   kick_prod;
    logic [15:0]   kick_diff;
    logic [15:0]   kick_rem16;
    logic [RW-1:0] kick_rem;
    logic          swap_b;
    logic [WW-1:0] swap_way;

    always_comb
    begin
        kick_prod  = 48'(lfsr_reg) * 48'(KickRecip);
        kick_diff  = lfsr_reg - 16'(q_reg * 16'(KickRange));
        kick_rem16 = (kick_diff >= 16'(KickRange)) ? kick_diff - 16'(KickRange) : kick_diff;
        kick_rem   = kick_rem16[RW-1:0];
        swap_b     = kick_rem >= RW'(WAYS);
        swap_way   = swap_b ? WW'(kick_rem - RW'(WAYS)) : WW'(kick_rem);
        swap_row   = swap_b ? row_b : row_a_reg;
        swap_row[swap_way].key   = ck_reg;
        swap_row[swap_way].value = cv_reg;
    end

    // outcome of the compare cycle
    logic    out_free;
    logic    rejected;
    logic    give_up;
    logic    finish;
    status_t eval_status;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        rejected = (op_reg == OP_INSERT) && (ck_reg == KEY_EMPTY || cv_reg == KEY_EMPTY);
        give_up  = (op_reg == OP_INSERT) && !rejected && (kicks_reg >= kick_budget_reg);
        finish   = (op_reg == OP_LOOKUP) || rejected || give_up || home_hit;
        if (op_reg == OP_LOOKUP)
        begin
            eval_status = (ck_reg != KEY_EMPTY && found != KEY_EMPTY) ? ST_OK : ST_NOT_FOUND;
        end
        else if (rejected)
        begin
            eval_status = ST_REJECTED;
        end
        else if (give_up)
        begin
            eval_status = ST_FAILED;
        end
        else
        begin
            eval_status = ST_OK;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and memory control
    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = hash_a;
        wr_en      = 1'b0;
        wr_addr    = hash_a;
        wr_row     = home_row;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clear_cnt_reg;
                wr_row  = {WAYS{{KEY_EMPTY, KEY_EMPTY}}};
                if (clear_cnt_reg == BW'(BUCKET_CNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = S_READ_A;
                end
            end
            S_READ_A:
            begin
                rd_en      = 1'b1;
                state_next = S_READ_B;
            end
            S_READ_B:
            begin
                rd_en      = 1'b1;
                rd_addr    = hash_b;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                wr_addr = home_b ? hash_b : hash_a;
                if (!finish)
                begin
                    state_next = S_KICK;
                end
                else if (out_free)
                begin
                    wr_en      = (op_reg == OP_INSERT) && !rejected && !give_up;
                    state_next = S_IDLE;
                end
            end
            S_KICK:
            begin
                state_next = S_SWAP;
            end
            S_SWAP:
            begin
                wr_en      = 1'b1;
                wr_addr    = swap_b ? hash_b : hash_a;
                wr_row     = swap_row;
                state_next = S_READ_A;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_budget_reg <= KICK_BUDGET_RESET;
            lfsr_reg        <= LFSR_RESET;
            clear_cnt_reg   <= '0;
            kicks_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (state_reg == S_CLEAR)
            begin
                clear_cnt_reg <= clear_cnt_reg + BW'(1);
            end
            if (s_tvalid && s_tready)
            begin
                kicks_reg <= '0;
            end
            else if (state_reg == S_SWAP)
            begin
                kicks_reg <= kicks_reg + 9'd1;
            end
            // one lfsr step per eviction
            if (state_reg == S_EVAL && !finish)
            begin
                lfsr_reg <= lfsr_step(lfsr_reg);
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KICK_BUDGET: kick_budget_reg <= cfg_data[8:0];
                    CFG_KICK_SEED: lfsr_reg <= (cfg_data != 16'd0) ? cfg_data : LFSR_RESET;
                    default: ;
                endcase
            end
            if (state_reg == S_EVAL && finish && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item, row and result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg <= s_tuser;
            ck_reg <= s_tdata[63:0];
            cv_reg <= s_tdata[127:64];
        end
        else if (state_reg == S_SWAP)
        begin
            // evicted item becomes the carried one
            ck_reg <= swap_b ? row_b[swap_way].key : row_a_reg[swap_way].key;
            cv_reg <= swap_b ? row_b[swap_way].value : row_a_reg[swap_way].value;
        end
        if (state_reg == S_READ_B)
        begin
            row_a_reg <= row_b;
        end
        if (state_reg == S_KICK)
        begin
            q_reg <= kick_prod[47:32];
        end
        if (state_reg == S_EVAL && finish && out_free)
        begin
            out_status_reg <= eval_status;
            out_found_reg  <= (eval_status == ST_OK && op_reg == OP_LOOKUP) ? found : KEY_EMPTY;
            out_lk_reg     <= give_up ? ck_reg : KEY_EMPTY;
            out_lv_reg     <= give_up ? cv_reg : KEY_EMPTY;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_lv_reg, out_lk_reg, out_found_reg};

endmodule

`default_nettype wire

// ----- rtl/bcht_row_mem.sv -----
// ----------------------------------------------------------------------------
// bcht_row_mem
// bucket store: one row per bucket, one read and one write port
// ----------------------------------------------------------------------------
`default_nettype none

module bcht_row_mem
    import bcht_pkg::*;
#(
    parameter int BUCKET_CNT = 64,
    parameter int WAYS       = 4,
    parameter int AW         = $clog2(BUCKET_CNT)
) (
    input  wire logic                  clk,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output slot_t     [WAYS-1:0]       rd_data,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  slot_t     [WAYS-1:0]       wr_data
);

    slot_t [WAYS-1:0] mem [BUCKET_CNT];
    slot_t [WAYS-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/bcht_checker.sv -----
// ----------------------------------------------------------------------------
// bcht_checker
// port-level checks of the hash table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "bucketized_cuckoo_hash_table_defines.svh"

module bcht_checker
    import bcht_pkg::*;
(
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          s_tvalid,
    input wire logic          s_tready,
    input wire logic          m_tvalid,
    input wire logic          m_tready,
    input wire logic [191:0]  m_tdata,
    input wire logic [1:0]    m_tuser
);

    // a stalled result holds
    `BCHT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one item in work at a time
    `BCHT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")

    // a failed insert hands back a real item
    `BCHT_ASSERT_SAME(a_leftover, m_tvalid && m_tuser == ST_FAILED, m_tdata[127:64] != KEY_EMPTY && m_tdata[191:128] != KEY_EMPTY, "failed insert without leftover item")

    // only a successful lookup reports a value
    `BCHT_ASSERT_SAME(a_found, m_tvalid && m_tdata[63:0] != KEY_EMPTY, m_tuser == ST_OK && m_tdata[127:64] == KEY_EMPTY, "value reported without a hit")

endmodule

bind bucketized_cuckoo_hash_table bcht_checker u_bcht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- test/tb_bucketized_cuckoo_hash_table.sv -----
// ----------------------------------------------------------------------------
// tb_bucketized_cuckoo_hash_table
// self-checking bench for the cuckoo table: directed table of extremes and
// reserved keys, then random lookups and inserts from a key pool larger than
// the store, checked against a cycle-free predictor under four idling phases
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bucketized_cuckoo_hash_table;
    import bcht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBKT   = 64;
    localparam int NWAY   = 4;
    localparam int NSLOT  = NBKT * NWAY;
    localparam int POOL_N = 320;
    localparam int N_RAND = 170;

    typedef struct packed {
        status_t     st;
        logic [63:0] found;
        logic [63:0] left_key;
        logic [63:0] left_val;
    } result_t;

    typedef struct {
        bit          is_cfg;
        logic        op_or_idx;
        logic [63:0] key;
        logic [63:0] val;
        bit          typed;
        result_t     res;
    } row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata = '0;
    logic          s_tuser = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [191:0]  m_tdata;
    logic [1:0]    m_tuser;
    logic          cfg_we = 1'b0;
    logic          cfg_index = 1'b0;
    logic [15:0]   cfg_data = '0;

    // predictor state
    logic [63:0] tbl_key [NSLOT];
    logic [63:0] tbl_val [NSLOT];
    logic [15:0] kick_state;
    logic [8:0]  kick_limit;

    result_t     pending_results[$];
    logic [63:0] key_pool [POOL_N];
    int          err_count = 0;
    int          n_items = 0;
    int          n_results = 0;
    int          n_failed = 0;
    int          n_hits = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    bucketized_cuckoo_hash_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // key, value
        .s_tuser   (s_tuser),   // operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // found_value, leftover_key, leftover_value
        .m_tuser   (m_tuser),   // status
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // receiver stall
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int home_a(logic [63:0] k);
        logic [63:0] h;
        h = k * 64'd37 + 64'd13;
        return int'(h % NBKT);
    endfunction

    function automatic int home_b(logic [63:0] k);
        logic [63:0] h;
        h = k * 64'd31 + 64'd11;
        return int'(h % NBKT);
    endfunction

    // update a present key in bucket b
    function automatic bit table_update(int b, logic [63:0] k, logic [63:0] v);
        for (int w = 0; w < NWAY; w++)
        begin
            if (tbl_key[b*NWAY+w] == k)
            begin
                tbl_val[b*NWAY+w] = v;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // take the lowest empty way of bucket b
    function automatic bit table_fill(int b, logic [63:0] k, logic [63:0] v);
        for (int w = 0; w < NWAY; w++)
        begin
            if (tbl_key[b*NWAY+w] == KEY_EMPTY)
            begin
                tbl_key[b*NWAY+w] = k;
                tbl_val[b*NWAY+w] = v;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // expected outcome of one operation; advances the predictor state
    function automatic result_t cuckoo_outcome(logic op, logic [63:0] k, logic [63:0] v);
        result_t     r;
        logic [63:0] ck, cv, ek, ev;
        int          ba, bb, pick, slot;
        bit          placed;
        r = '{ST_OK, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY};
        if (op == OP_LOOKUP)
        begin
            r.st = ST_NOT_FOUND;
            if (k != KEY_EMPTY)
            begin
                ba = home_a(k);
                bb = home_b(k);
                // second bucket and higher ways win
                for (int w = 0; w < NWAY; w++)
                    if (tbl_key[ba*NWAY+w] == k) r.found = tbl_val[ba*NWAY+w];
                for (int w = 0; w < NWAY; w++)
                    if (tbl_key[bb*NWAY+w] == k) r.found = tbl_val[bb*NWAY+w];
                if (r.found != KEY_EMPTY) r.st = ST_OK;
            end
        end
        else if (k == KEY_EMPTY || v == KEY_EMPTY)
        begin
            r.st = ST_REJECTED;
        end
        else
        begin
            ck = k;
            cv = v;
            placed = 1'b0;
            for (int i = 0; i < kick_limit && !placed; i++)
            begin
                ba = home_a(ck);
                bb = home_b(ck);
                if (table_update(ba, ck, cv) || table_update(bb, ck, cv) ||
                    table_fill(ba, ck, cv) || table_fill(bb, ck, cv))
                begin
                    placed = 1'b1;
                end
                else
                begin
                    kick_state = kick_state[0] ? ((kick_state >> 1) ^ 16'hB400)
                                               : (kick_state >> 1);
                    pick = kick_state % (2 * NWAY);
                    slot = (pick < NWAY) ? ba*NWAY + pick : bb*NWAY + pick - NWAY;
                    ek = tbl_key[slot];
                    ev = tbl_val[slot];
                    tbl_key[slot] = ck;
                    tbl_val[slot] = cv;
                    ck = ek;
                    cv = ev;
                end
            end
            if (!placed)
            begin
                r.st = ST_FAILED;
                r.left_key = ck;
                r.left_val = cv;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        err_count++;
        $display("mismatch on result %0d: %s got %h expected %h", n_results, field, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected transfer", {62'd0, m_tuser}, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser != want.st)
                    report_mismatch("status", {62'd0, m_tuser}, {62'd0, want.st});
                if (m_tdata[63:0] != want.found)
                    report_mismatch("found_value", m_tdata[63:0], want.found);
                if (m_tdata[127:64] != want.left_key)
                    report_mismatch("leftover_key", m_tdata[127:64], want.left_key);
                if (m_tdata[191:128] != want.left_val)
                    report_mismatch("leftover_value", m_tdata[191:128], want.left_val);
                if (want.st == ST_FAILED) n_failed++;
                if (want.st == ST_OK && want.found != KEY_EMPTY) n_hits++;
            end
            n_results++;
        end
    end

    // one input transfer; valid is left high so the next item can follow at once
    task automatic send_item(logic op, logic [63:0] k, logic [63:0] v,
                             bit typed, result_t typed_res);
        result_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, k};
        do @(posedge clk); while (!s_tready);
        r = cuckoo_outcome(op, k, v);
        pending_results.push_back(typed ? typed_res : r);
        n_items++;
    endtask

    // stop sending and let the block go idle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_KICK_BUDGET)
            kick_limit = data[8:0];
        else
            kick_state = (data != 16'd0) ? data : 16'd1;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // directed stimulus; keys 21 + 64n share one bucket for both hashes
    row_t directed [] = '{
        '{0, OP_LOOKUP, 64'd0, 64'd0, 1, '{ST_NOT_FOUND, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY}},
        '{0, OP_INSERT, KEY_EMPTY, 64'd5, 1, '{ST_REJECTED, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY}},
        '{0, OP_INSERT, 64'd7, KEY_EMPTY, 1, '{ST_REJECTED, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY}},
        '{0, OP_LOOKUP, KEY_EMPTY, 64'd0, 1, '{ST_NOT_FOUND, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY}},
        '{0, OP_INSERT, 64'd0, 64'd0, 1, '{ST_OK, KEY_EMPTY, KEY_EMPTY, KEY_EMPTY}},
        '{0, OP_LOOKUP, 64'd0, 64'd0, 1, '{ST_OK, 64'd0, KEY_EMPTY, KEY_EMPTY}},
        '{0, OP_INSERT, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 64'd1, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_LOOKUP, 64'd0, 64'd0, 0, '{ST_OK, '0, '0, '0}},
        '{1, CFG_KICK_BUDGET, 64'd0, 64'd0, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_INSERT, 64'd21, 64'd100, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_INSERT, 64'd85, 64'd101, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_INSERT, 64'd149, 64'd102, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_INSERT, 64'd213, 64'd103, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_INSERT, 64'd277, 64'd104,
          1, '{ST_FAILED, KEY_EMPTY, 64'd277, 64'd104}},
        '{0, OP_LOOKUP, 64'd277, 64'd0, 0, '{ST_OK, '0, '0, '0}},
        '{1, CFG_KICK_BUDGET, 64'd0, 64'd3, 0, '{ST_OK, '0, '0, '0}},
        '{1, CFG_KICK_SEED, 64'd0, 64'd0, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_INSERT, 64'd341, 64'd105, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_INSERT, 64'd405, 64'd106, 0, '{ST_OK, '0, '0, '0}},
        '{1, CFG_KICK_BUDGET, 64'd0, 64'd256, 0, '{ST_OK, '0, '0, '0}},
        '{1, CFG_KICK_SEED, 64'd0, 64'hFFFF, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_INSERT, 64'd469, 64'd107, 0, '{ST_OK, '0, '0, '0}},
        '{0, OP_LOOKUP, 64'd21, 64'd0, 0, '{ST_OK, '0, '0, '0}}
    };

    initial
    begin
        logic [63:0] k, v;
        logic        op;
        int          sel;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_key[i] = KEY_EMPTY;
            tbl_val[i] = KEY_EMPTY;
        end
        kick_limit = KICK_BUDGET_RESET;
        kick_state = LFSR_RESET;
        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = ($urandom_range(3) == 0) ? 64'(i) : rand64();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                drain();
                write_reg(directed[i].op_or_idx, directed[i].val[15:0]);
            end
            else
            begin
                send_item(directed[i].op_or_idx, directed[i].key, directed[i].val,
                          directed[i].typed, directed[i].res);
            end
        end

        // random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0: write_reg(CFG_KICK_BUDGET, 16'd256);
                1: write_reg(CFG_KICK_BUDGET, 16'd1);
                2: write_reg(CFG_KICK_BUDGET, 16'($urandom_range(40, 2)));
                default: write_reg(CFG_KICK_BUDGET, 16'd511);
            endcase
            write_reg(CFG_KICK_SEED, (ph == 3) ? 16'd1 : 16'($urandom()));
            idle_pct  = (ph == 1) ? 67 : (ph == 3) ? 19 : 0;
            stall_pct = (ph == 2) ? 67 : (ph == 3) ? 19 : 0;
            for (int n = 0; n < N_RAND; n++)
            begin
                sel = $urandom_range(99);
                op  = 1'($urandom_range(1));
                k   = (sel < 80) ? key_pool[$urandom_range(POOL_N - 1)] : rand64();
                v   = rand64();
                if (sel >= 97) k = KEY_EMPTY;
                if ($urandom_range(49) == 0) v = KEY_EMPTY;
                send_item(op, k, v, 1'b0, '{ST_OK, '0, '0, '0});
            end
        end

        drain();
        repeat (50) @(posedge clk);
        $display("ran %0d items, %0d results: %0d lookup hits, %0d failed inserts",
                 n_items, n_results, n_hits, n_failed);
        $display("four idling phases, kick limits 0 to 511, seeds including zero");
        if (err_count == 0 && pending_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #60ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
